### src/ber_lsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_lsm_pkg
// Shared types and constants for the BER link status monitor.
// ----------------------------------------------------------------------------
package ber_lsm_pkg;

    localparam int LOSS_WIDTH = 32;

    // command field
    localparam logic CMD_STATUS  = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    // control codes, anything else acts as start
    localparam logic [7:0] CTRL_START       = 8'h00;
    localparam logic [7:0] CTRL_STOP        = 8'h01;
    localparam logic [7:0] CTRL_CLEAR_START = 8'h02;

    // status byte bit positions
    localparam int STS_SYNC_BIT  = 0;
    localparam int STS_LOSS_BIT  = 1;
    localparam int STS_ZEROS_BIT = 5;
    localparam int STS_ONES_BIT  = 6;

    // active-low led byte
    localparam logic [7:0] LED_IDLE       = 8'hfd;
    localparam logic [7:0] LED_NOSYNC_MSK = 8'hfe;
    localparam logic [7:0] LED_ONES_MSK   = 8'hf7;
    localparam logic [7:0] LED_ZEROS_MSK  = 8'hfb;
    localparam logic [7:0] LED_TEST_MSK   = 8'hef;

    // configuration register indexes
    localparam logic REG_BER_INSERT_LEVEL = 1'b0;
    localparam logic REG_LOOPBACK_ENABLE  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] status_byte;
        logic [7:0] control_code;
    } t_item_hdr;

endpackage

### src/ber_lsm_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_lsm_in_stage
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module ber_lsm_in_stage #(
    parameter int DELTA_WIDTH = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ber_lsm_pkg::t_item_hdr      i_hdr,
    input  logic [DELTA_WIDTH-1:0]      i_bit_delta,
    input  logic [DELTA_WIDTH-1:0]      i_error_delta,
    input  logic                        i_take,
    output logic                        o_valid,
    output ber_lsm_pkg::t_item_hdr      o_hdr,
    output logic [DELTA_WIDTH-1:0]      o_bit_delta,
    output logic [DELTA_WIDTH-1:0]      o_error_delta
);
    import ber_lsm_pkg::*;

    logic                   r_valid;
    t_item_hdr              r_hdr;
    logic [DELTA_WIDTH-1:0] r_bit_delta;
    logic [DELTA_WIDTH-1:0] r_error_delta;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_hdr         <= i_hdr;
            r_bit_delta   <= i_bit_delta;
            r_error_delta <= i_error_delta;
        end
    end

    assign o_valid       = r_valid;
    assign o_hdr         = r_hdr;
    assign o_bit_delta   = r_bit_delta;
    assign o_error_delta = r_error_delta;

endmodule

### src/ber_lsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_lsm_core
// Monitor state and its combinational update; drives the result of the
// item being consumed.
// ----------------------------------------------------------------------------
module ber_lsm_core #(
    parameter int TOTAL_WIDTH = 56,
    parameter int DELTA_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  ber_lsm_pkg::t_item_hdr              i_hdr,
    input  logic [DELTA_WIDTH-1:0]              i_bit_delta,
    input  logic [DELTA_WIDTH-1:0]              i_error_delta,
    input  logic [2:0]                          i_ber_insert_level,
    input  logic                                i_loopback_enable,
    output logic [7:0]                          o_led_pattern,
    output logic [ber_lsm_pkg::LOSS_WIDTH-1:0]  o_loss_events,
    output logic [TOTAL_WIDTH-1:0]              o_bit_total,
    output logic [TOTAL_WIDTH-1:0]              o_error_total,
    output logic                                o_in_sync,
    output logic                                o_running
);
    import ber_lsm_pkg::*;

    localparam int PAD_WIDTH = TOTAL_WIDTH + 1 - DELTA_WIDTH;

    logic                   r_run, r_latched, r_sync, r_ones, r_zeros;
    logic [LOSS_WIDTH-1:0]  r_loss_cnt;
    logic [TOTAL_WIDTH-1:0] r_bits, r_errors;

    logic                   n_run, n_latched, n_sync, n_ones, n_zeros;
    logic [LOSS_WIDTH-1:0]  n_loss_cnt;
    logic [TOTAL_WIDTH-1:0] n_bits, n_errors;

    logic                   loss_set, latched_mid, resolved, accumulate;
    logic [TOTAL_WIDTH:0]   bits_sum, errors_sum;
    logic [7:0]             led;

    assign bits_sum   = {1'b0, r_bits} + {{PAD_WIDTH{1'b0}}, i_bit_delta};
    assign errors_sum = {1'b0, r_errors} + {{PAD_WIDTH{1'b0}}, i_error_delta};

    always_comb begin
        n_run      = r_run;
        n_latched  = r_latched;
        n_sync     = r_sync;
        n_ones     = r_ones;
        n_zeros    = r_zeros;
        n_loss_cnt = r_loss_cnt;
        n_bits     = r_bits;
        n_errors   = r_errors;

        loss_set    = i_hdr.status_byte[STS_LOSS_BIT] && !r_latched;
        latched_mid = r_latched || loss_set;
        resolved    = i_hdr.status_byte[STS_SYNC_BIT] && latched_mid;
        accumulate  = i_hdr.status_byte[STS_SYNC_BIT] && r_run
                      && !i_hdr.status_byte[STS_ONES_BIT]
                      && !i_hdr.status_byte[STS_ZEROS_BIT];

        if (i_hdr.command == CMD_STATUS) begin
            n_sync    = i_hdr.status_byte[STS_SYNC_BIT];
            n_ones    = i_hdr.status_byte[STS_ONES_BIT];
            n_zeros   = i_hdr.status_byte[STS_ZEROS_BIT];
            n_latched = latched_mid && !resolved;
            if (loss_set && (r_loss_cnt != {LOSS_WIDTH{1'b1}})) begin
                n_loss_cnt = r_loss_cnt + 1'b1;
            end
            if (resolved) begin
                n_bits   = '0;
                n_errors = '0;
            end else if (accumulate) begin
                n_bits   = bits_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}}
                                                 : bits_sum[TOTAL_WIDTH-1:0];
                n_errors = errors_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}}
                                                   : errors_sum[TOTAL_WIDTH-1:0];
            end
        end else begin
            case (i_hdr.control_code)
                CTRL_STOP: begin
                    n_run = 1'b0;
                end
                CTRL_CLEAR_START: begin
                    n_run      = 1'b1;
                    n_bits     = '0;
                    n_errors   = '0;
                    n_loss_cnt = '0;
                end
                default: begin
                    n_run = 1'b1;
                end
            endcase
        end
    end

    // led bit1 stays low, all others active low
    always_comb begin
        led = LED_IDLE;
        if (!n_sync) begin
            led = led & LED_NOSYNC_MSK;
        end
        if (n_ones) begin
            led = led & LED_ONES_MSK;
        end
        if (n_zeros) begin
            led = led & LED_ZEROS_MSK;
        end
        if ((i_ber_insert_level != 3'd0) || i_loopback_enable) begin
            led = led & LED_TEST_MSK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_latched  <= 1'b0;
            r_sync     <= 1'b0;
            r_ones     <= 1'b0;
            r_zeros    <= 1'b0;
            r_loss_cnt <= '0;
            r_bits     <= '0;
            r_errors   <= '0;
        end else if (i_advance) begin
            r_run      <= n_run;
            r_latched  <= n_latched;
            r_sync     <= n_sync;
            r_ones     <= n_ones;
            r_zeros    <= n_zeros;
            r_loss_cnt <= n_loss_cnt;
            r_bits     <= n_bits;
            r_errors   <= n_errors;
        end
    end

    assign o_led_pattern = led;
    assign o_loss_events = n_loss_cnt;
    assign o_bit_total   = n_bits;
    assign o_error_total = n_errors;
    assign o_in_sync     = n_sync;
    assign o_running     = n_run;

endmodule

### src/ber_link_status_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_link_status_monitor_top
// BER tester monitor: status decode, loss counting, saturating totals, LEDs.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// result per item. An accepted item is captured in the input register, the
// monitor state is updated from it and the result lands in the output
// register, from which it is offered. The state update (flag decode, loss
// counter, two saturating TOTAL_WIDTH-bit adds) sets the rate; a stalled
// output holds the input register but the block keeps taking one more item
// while the result waits.
module ber_link_status_monitor_top #(
    parameter int TOTAL_WIDTH = 56,
    parameter int DELTA_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_index,
    input  logic [2:0]                          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic [7:0]                          i_status_byte,
    input  logic [7:0]                          i_control_code,
    input  logic [DELTA_WIDTH-1:0]              i_bit_delta,
    input  logic [DELTA_WIDTH-1:0]              i_error_delta,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_led_pattern,
    output logic [ber_lsm_pkg::LOSS_WIDTH-1:0]  o_loss_events,
    output logic [TOTAL_WIDTH-1:0]              o_bit_total,
    output logic [TOTAL_WIDTH-1:0]              o_error_total,
    output logic                                o_in_sync,
    output logic                                o_running
);
    import ber_lsm_pkg::*;

    logic [2:0] r_ber_insert_level;
    logic       r_loopback_enable;

    t_item_hdr              in_hdr, st_hdr;
    logic                   st_valid, advance;
    logic [DELTA_WIDTH-1:0] st_bit_delta, st_error_delta;

    logic [7:0]             res_led;
    logic [LOSS_WIDTH-1:0]  res_loss;
    logic [TOTAL_WIDTH-1:0] res_bits, res_errors;
    logic                   res_sync, res_run;

    logic                   r_out_valid;
    logic [7:0]             r_led;
    logic [LOSS_WIDTH-1:0]  r_loss;
    logic [TOTAL_WIDTH-1:0] r_bits, r_errors;
    logic                   r_sync, r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ber_insert_level <= 3'd0;
            r_loopback_enable  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BER_INSERT_LEVEL: r_ber_insert_level <= i_cfg_data;
                REG_LOOPBACK_ENABLE:  r_loopback_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_hdr.command      = i_command;
    assign in_hdr.status_byte  = i_status_byte;
    assign in_hdr.control_code = i_control_code;

    // core consumes the staged item when the result register is free or being read
    assign advance = st_valid && (!r_out_valid || i_ready);

    ber_lsm_in_stage #(
        .DELTA_WIDTH(DELTA_WIDTH)
    ) u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_hdr         (in_hdr),
        .i_bit_delta   (i_bit_delta),
        .i_error_delta (i_error_delta),
        .i_take        (advance),
        .o_valid       (st_valid),
        .o_hdr         (st_hdr),
        .o_bit_delta   (st_bit_delta),
        .o_error_delta (st_error_delta)
    );

    ber_lsm_core #(
        .TOTAL_WIDTH(TOTAL_WIDTH),
        .DELTA_WIDTH(DELTA_WIDTH)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (advance),
        .i_hdr              (st_hdr),
        .i_bit_delta        (st_bit_delta),
        .i_error_delta      (st_error_delta),
        .i_ber_insert_level (r_ber_insert_level),
        .i_loopback_enable  (r_loopback_enable),
        .o_led_pattern      (res_led),
        .o_loss_events      (res_loss),
        .o_bit_total        (res_bits),
        .o_error_total      (res_errors),
        .o_in_sync          (res_sync),
        .o_running          (res_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_led    <= res_led;
            r_loss   <= res_loss;
            r_bits   <= res_bits;
            r_errors <= res_errors;
            r_sync   <= res_sync;
            r_run    <= res_run;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_led_pattern = r_led;
    assign o_loss_events = r_loss;
    assign o_bit_total   = r_bits;
    assign o_error_total = r_errors;
    assign o_in_sync     = r_sync;
    assign o_running     = r_run;

endmodule
